// File: hw/rtl/etxpad_pkg.sv
// shared types, constants and codes for the ethernet tx pad and fcs insert block
// no dependencies
package etxpad_pkg;

  localparam int FCS_LEN = 4;
  localparam int FcsIdxW = $clog2(FCS_LEN);

  localparam int CNT_W = 7;
  localparam logic [CNT_W-1:0] COUNT_CAP = 7'd64;

  localparam int CFG_W = 7;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FCS_SEL   = 1'b1;

  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam logic [31:0] CRC_PRESET = 32'hFFFFFFFF;
  localparam logic [31:0] MARK_GOOD  = 32'hC00DC00D;
  localparam logic [31:0] MARK_BAD   = 32'hBAADBAAD;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_PAD  = 2'd1;
  localparam logic [1:0] KIND_FCS  = 2'd2;

  typedef enum logic [1:0] {
    FCS_CRC  = 2'd0,
    FCS_GOOD = 2'd1,
    FCS_BAD  = 2'd2
  } fcs_sel_t;

endpackage

// File: hw/rtl/etxpad_in_if.sv
// input byte channel: valid/ready handshake with one frame byte and end mark
// no dependencies
interface etxpad_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

// File: hw/rtl/etxpad_out_if.sv
// result byte channel: valid/ready handshake with byte, kind and last mark
// no dependencies
interface etxpad_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] byte_kind;
  logic       frame_last;

  modport source (output valid, output out_byte, output byte_kind, output frame_last,
                  input ready);
  modport sink   (input valid, input out_byte, input byte_kind, input frame_last,
                  output ready);
endinterface

// File: hw/rtl/ethernet_tx_pad_and_fcs_insert_top.sv
// top level of the ethernet tx pad and fcs insert block
// depends on etxpad_pkg, etxpad_in_if, etxpad_out_if, etxpad_crc8
//
// usage
//   in_chan  : frame bytes without fcs, one per transfer, frame_end on the last
//   out_chan : every data byte, then zero padding up to cfg min_frame_bytes
//              (counting the fcs, capped at 64), then four fcs bytes, lsb first;
//              byte_kind tells data / pad / fcs, frame_last marks the final byte
//   cfg_*    : write port; index 0 min_frame_bytes, index 1 fcs_select
//              (0 computed crc, 1 good marker, 2 or 3 bad marker); written idle
// path: a data byte passes the input register, then the result register,
//   before it is presented on out_chan
// throughput: one byte per cycle in both directions while out_chan is ready;
//   after a frame end the input holds off for the pad and fcs burst, one output
//   byte per cycle, set by the single result register every byte passes through
// reset (rst_n low, synchronous): crc preset to all ones, count zero,
//   min_frame_bytes 64, fcs_select computed crc, both registers empty
// receiver stall: the result register holds its byte; the input register still
//   takes one more byte, after which in_chan.ready drops until out_chan moves
module ethernet_tx_pad_and_fcs_insert_top
  import etxpad_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  etxpad_in_if.sink            in_chan,
  etxpad_out_if.source         out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  typedef enum logic [1:0] {
    ST_PASS,
    ST_PAD,
    ST_FCS
  } state_t;

  // control state
  state_t             state_r, state_nxt;
  logic               in_valid_r, in_valid_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        crc_r, crc_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [FcsIdxW-1:0] fcs_idx_r, fcs_idx_nxt;
  logic [CFG_W-1:0]   cfg_min_r;
  fcs_sel_t           cfg_sel_r;

  // payload registers
  logic [7:0]         in_byte_r, in_byte_nxt;
  logic               in_end_r, in_end_nxt;
  logic [7:0]         out_byte_r, out_byte_nxt;
  logic [1:0]         out_kind_r, out_kind_nxt;
  logic               out_last_r, out_last_nxt;

  logic               out_free;
  logic               take_in;
  logic [7:0]         crc_byte;
  logic [31:0]        crc_step;
  logic [CNT_W-1:0]   cnt_inc;
  logic [CNT_W-1:0]   min_eff;
  logic               pad_more;
  logic [31:0]        fcs_word;
  logic [31:0]        fcs_shift;

  etxpad_crc8 u_crc (
    .crc_in  (crc_r),
    .byte_in (crc_byte),
    .crc_out (crc_step)
  );

  // result register can load when empty or being drained this cycle
  assign out_free = !out_valid_r || out_chan.ready;
  assign take_in  = in_valid_r && (state_r == ST_PASS) && out_free;
  assign in_chan.ready = !in_valid_r || take_in;

  // padding bytes feed zero into the crc
  assign crc_byte = (state_r == ST_PASS) ? in_byte_r : 8'h00;

  // saturating count after absorbing one more byte
  assign cnt_inc = (cnt_r == COUNT_CAP) ? cnt_r : cnt_r + CNT_W'(1);

  // minimum above 64 acts as 64
  assign min_eff  = (cfg_min_r > COUNT_CAP) ? COUNT_CAP : cfg_min_r;
  assign pad_more = (cnt_inc + CNT_W'(FCS_LEN)) < min_eff;

  always_comb begin
    case (cfg_sel_r)
      FCS_CRC:  fcs_word = ~crc_r;
      FCS_GOOD: fcs_word = MARK_GOOD;
      default:  fcs_word = MARK_BAD;
    endcase
  end

  // fcs goes out least significant byte first
  assign fcs_shift = fcs_word >> {fcs_idx_r, 3'b000};

  always_comb begin
    state_nxt     = state_r;
    crc_nxt       = crc_r;
    cnt_nxt       = cnt_r;
    fcs_idx_nxt   = fcs_idx_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_byte_nxt  = out_byte_r;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;

    // input register: refill on transfer, empty when consumed
    in_valid_nxt  = in_valid_r;
    in_byte_nxt   = in_byte_r;
    in_end_nxt    = in_end_r;
    if (in_chan.valid && in_chan.ready) begin
      in_valid_nxt = 1'b1;
      in_byte_nxt  = in_chan.data_byte;
      in_end_nxt   = in_chan.frame_end;
    end else if (take_in) begin
      in_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_PASS: begin
        if (take_in) begin
          crc_nxt       = crc_step;
          cnt_nxt       = cnt_inc;
          out_valid_nxt = 1'b1;
          out_byte_nxt  = in_byte_r;
          out_kind_nxt  = KIND_DATA;
          out_last_nxt  = 1'b0;
          fcs_idx_nxt   = '0;
          if (in_end_r) begin
            state_nxt = pad_more ? ST_PAD : ST_FCS;
          end
        end
      end
      ST_PAD: begin
        if (out_free) begin
          crc_nxt       = crc_step;
          cnt_nxt       = cnt_inc;
          out_valid_nxt = 1'b1;
          out_byte_nxt  = 8'h00;
          out_kind_nxt  = KIND_PAD;
          out_last_nxt  = 1'b0;
          if (!pad_more) begin
            state_nxt = ST_FCS;
          end
        end
      end
      ST_FCS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = fcs_shift[7:0];
          out_kind_nxt  = KIND_FCS;
          out_last_nxt  = 1'b0;
          fcs_idx_nxt   = fcs_idx_r + FcsIdxW'(1);
          if (fcs_idx_r == FcsIdxW'(FCS_LEN - 1)) begin
            // frame done: back to preset for the next frame
            out_last_nxt = 1'b1;
            crc_nxt      = CRC_PRESET;
            cnt_nxt      = '0;
            fcs_idx_nxt  = '0;
            state_nxt    = ST_PASS;
          end
        end
      end
      default: begin
        state_nxt = ST_PASS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_PASS;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      crc_r       <= CRC_PRESET;
      cnt_r       <= '0;
      fcs_idx_r   <= '0;
      cfg_min_r   <= CFG_W'(64);
      cfg_sel_r   <= FCS_CRC;
    end else begin
      state_r     <= state_nxt;
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      crc_r       <= crc_nxt;
      cnt_r       <= cnt_nxt;
      fcs_idx_r   <= fcs_idx_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_FRAME: cfg_min_r <= cfg_wdata;
          CFG_FCS_SEL:   cfg_sel_r <= fcs_sel_t'(cfg_wdata[1:0]);
          default: begin
          end
        endcase
      end
    end
    in_byte_r  <= in_byte_nxt;
    in_end_r   <= in_end_nxt;
    out_byte_r <= out_byte_nxt;
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.out_byte   = out_byte_r;
  assign out_chan.byte_kind  = out_kind_r;
  assign out_chan.frame_last = out_last_r;

`ifndef SYNTH
  // no input byte is consumed during a pad or fcs burst
  a_no_take_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_PASS) |-> !take_in)
    else $error("input byte consumed during pad or fcs burst");

  // the last byte of a frame is always an fcs byte
  a_last_is_fcs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_kind_r == KIND_FCS))
    else $error("frame_last on a non-fcs byte");

  // once the final fcs byte is loaded, crc and count are back at preset
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FCS && out_free && fcs_idx_r == FcsIdxW'(FCS_LEN - 1))
    |=> (state_r == ST_PASS && cnt_r == '0 && crc_r == CRC_PRESET))
    else $error("crc or count not restarted after frame");

  // byte count never passes its cap
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= COUNT_CAP)
    else $error("byte count above cap");
`endif

endmodule

// File: hw/rtl/etxpad_crc8.sv
// one-byte update of the reflected ieee 802.3 crc-32
// depends on etxpad_pkg
module etxpad_crc8
  import etxpad_pkg::*;
(
  input  logic [31:0] crc_in,
  input  logic [7:0]  byte_in,
  output logic [31:0] crc_out
);

  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'h000000, byte_in};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    crc_out = c;
  end

endmodule

// File: tb/tb.sv
// self-checking bench for ethernet_tx_pad_and_fcs_insert_top: directed table, then random frames
// depends on etxpad_pkg, etxpad_in_if, etxpad_out_if and the block itself
`timescale 1ns / 100ps

module tb;
  import etxpad_pkg::*;

  // one byte seen on the result channel
  typedef struct packed {
    logic [7:0] val;
    logic [1:0] kind;
    logic       last;
  } beat_t;

  // one directed row: settings in force, the input byte, and a literal expectation if lit
  typedef struct packed {
    logic [6:0]  min_len;
    logic [1:0]  sel;
    logic [7:0]  data;
    logic        fend;
    logic        lit;
    logic [6:0]  npad;
    logic [31:0] fcs;
  } dir_row_t;

  localparam int DIR_N      = 22;
  localparam int RAND_ITEMS = 280;
  localparam int HOLD_LEN   = 300;

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  etxpad_in_if  in_chan ();
  etxpad_out_if out_chan ();

  ethernet_tx_pad_and_fcs_insert_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the block: running crc, saturating byte count and both registers
  logic [31:0] crc_acc;
  logic [6:0]  bytes_cnt;
  logic [6:0]  cur_min;
  logic [1:0]  cur_sel;

  beat_t beats_due [$];   // bytes the block still owes, oldest first
  beat_t pred_q [$];      // bytes caused by the latest input transfer

  int errors    = 0;
  int n_in      = 0;
  int n_frames  = 0;
  int n_beats   = 0;
  int n_setting = 0;

  // flags shared with the two handshake processes
  bit tx_no_gap   = 0;
  bit rx_no_gap   = 0;
  int rx_hold_len = 0;

  dir_row_t dir_rows [DIR_N];

  // reflected crc-32, one byte
  function automatic logic [31:0] crc32_step(logic [31:0] c, logic [7:0] b);
    c = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  task automatic absorb_byte(input logic [7:0] b);
    crc_acc = crc32_step(crc_acc, b);
    if (bytes_cnt < COUNT_CAP) bytes_cnt = bytes_cnt + 1'b1;
  endtask

  // works out every byte caused by one accepted input byte into pred_q
  task automatic predict_beats(input logic [7:0] d, input logic fend);
    int          pad_target;
    logic [31:0] fcs_word;
    pred_q.delete();
    absorb_byte(d);
    pred_q.push_back('{d, KIND_DATA, 1'b0});
    if (fend) begin
      // a minimum above the count cap acts as the cap
      pad_target = (cur_min > COUNT_CAP) ? int'(COUNT_CAP) : int'(cur_min);
      while (int'(bytes_cnt) + FCS_LEN < pad_target) begin
        absorb_byte(8'h00);
        pred_q.push_back('{8'h00, KIND_PAD, 1'b0});
      end
      if (cur_sel == FCS_CRC) fcs_word = ~crc_acc;
      else if (cur_sel == FCS_GOOD) fcs_word = MARK_GOOD;
      else fcs_word = MARK_BAD;   // the unused selector gives the bad marker too
      for (int i = 0; i < FCS_LEN; i++) begin
        pred_q.push_back('{fcs_word[8*i +: 8], KIND_FCS, (i == FCS_LEN - 1)});
      end
      crc_acc   = CRC_PRESET;
      bytes_cnt = '0;
    end
  endtask

  // offers one byte after a random gap and returns at the edge of its transfer
  task automatic send_byte(input logic [7:0] d, input logic fend);
    int gap;
    gap = tx_no_gap ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.data_byte <= d;
    in_chan.frame_end <= fend;
    do @(posedge clk); while (!in_chan.ready);
    n_in++;
    if (fend) n_frames++;
  endtask

  // sender pauses until every owed byte has come out
  task automatic drain_out;
    in_chan.valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // writes both registers on back-to-back edges; upper select bits get junk
  task automatic cfg_apply(input logic [6:0] min_len, input logic [1:0] sel);
    logic [4:0] junk;
    junk = 5'($urandom_range(0, 31));
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MIN_FRAME;
    cfg_wdata <= min_len;
    @(posedge clk);
    cfg_index <= CFG_FCS_SEL;
    cfg_wdata <= {junk, sel};
    @(posedge clk);
    cfg_we  <= 1'b0;
    cur_min = min_len;
    cur_sel = sel;
    n_setting++;
  endtask

  // result checker: every transfer on out_chan against the oldest owed byte
  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      n_beats++;
      if (beats_due.size() == 0) begin
        $error("unexpected output byte %0h kind %0d", out_chan.out_byte, out_chan.byte_kind);
        errors++;
      end else begin
        want = beats_due.pop_front();
        if (out_chan.out_byte !== want.val) begin
          $error("out_byte: expected %0h, got %0h", want.val, out_chan.out_byte);
          errors++;
        end
        if (out_chan.byte_kind !== want.kind) begin
          $error("byte_kind: expected %0d, got %0d", want.kind, out_chan.byte_kind);
          errors++;
        end
        if (out_chan.frame_last !== want.last) begin
          $error("frame_last: expected %0d, got %0d", want.last, out_chan.frame_last);
          errors++;
        end
      end
    end
  end

  // receiver: random stall before each byte, plus one long hold-off on request
  initial begin
    int gap;
    int hold;
    out_chan.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_hold_len > 0) begin
        // long hold-off so the block fills and stalls its input
        hold = rx_hold_len;
        rx_hold_len = 0;
        out_chan.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      gap = rx_no_gap ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!(out_chan.valid && out_chan.ready) && rx_hold_len == 0);
    end
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #15_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // stimulus
  initial begin
    int       flen;
    int       n_rand;
    int       phase;
    int       nfr;
    logic [6:0] rmin;
    logic [1:0] rsel;
    dir_row_t row;

    // directed rows: min, sel, byte, end, literal?, pad count, fcs word
    dir_rows = '{
      // after reset: plain data byte, then a crc frame padded to 64
      '{7'd64,  FCS_CRC,  8'h00, 1'b0, 1'b1, 7'd0,  32'h0},
      '{7'd64,  FCS_CRC,  8'hFF, 1'b1, 1'b0, 7'd0,  32'h0},
      // one-byte frames with fixed markers, full padding and none
      '{7'd64,  FCS_GOOD, 8'hA5, 1'b1, 1'b1, 7'd59, MARK_GOOD},
      '{7'd0,   FCS_BAD,  8'h5A, 1'b1, 1'b1, 7'd0,  MARK_BAD},
      // unused selector value behaves as the bad marker
      '{7'd0,   2'd3,     8'h80, 1'b1, 1'b1, 7'd0,  MARK_BAD},
      '{7'd0,   FCS_CRC,  8'h01, 1'b1, 1'b0, 7'd0,  32'h0},
      // minimum above the cap pads only to 64
      '{7'd65,  FCS_GOOD, 8'h7F, 1'b1, 1'b1, 7'd59, MARK_GOOD},
      '{7'd127, FCS_CRC,  8'hFE, 1'b1, 1'b0, 7'd0,  32'h0},
      // frame already long enough: no padding
      '{7'd1,   FCS_GOOD, 8'h3C, 1'b0, 1'b1, 7'd0,  32'h0},
      '{7'd1,   FCS_GOOD, 8'hC3, 1'b1, 1'b1, 7'd0,  MARK_GOOD},
      '{7'd6,   FCS_GOOD, 8'h11, 1'b0, 1'b1, 7'd0,  32'h0},
      '{7'd6,   FCS_GOOD, 8'h22, 1'b1, 1'b1, 7'd0,  MARK_GOOD},
      // register write between two bytes of one frame
      '{7'd7,   FCS_GOOD, 8'h33, 1'b0, 1'b1, 7'd0,  32'h0},
      '{7'd9,   FCS_BAD,  8'h44, 1'b1, 1'b1, 7'd3,  MARK_BAD},
      '{7'd5,   FCS_CRC,  8'h00, 1'b0, 1'b0, 7'd0,  32'h0},
      '{7'd5,   FCS_CRC,  8'hFF, 1'b0, 1'b0, 7'd0,  32'h0},
      '{7'd5,   FCS_CRC,  8'h00, 1'b1, 1'b0, 7'd0,  32'h0},
      '{7'd60,  FCS_BAD,  8'h01, 1'b1, 1'b1, 7'd55, MARK_BAD},
      '{7'd61,  FCS_GOOD, 8'hAA, 1'b1, 1'b1, 7'd56, MARK_GOOD},
      '{7'd8,   FCS_CRC,  8'h55, 1'b0, 1'b0, 7'd0,  32'h0},
      '{7'd8,   FCS_CRC,  8'hF0, 1'b0, 1'b0, 7'd0,  32'h0},
      '{7'd8,   FCS_CRC,  8'h0F, 1'b1, 1'b0, 7'd0,  32'h0}
    };

    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.data_byte <= 8'h00;
    in_chan.frame_end <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_MIN_FRAME;
    cfg_wdata         <= '0;
    crc_acc   = CRC_PRESET;
    bytes_cnt = '0;
    cur_min   = 7'd64;
    cur_sel   = FCS_CRC;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    for (int i = 0; i < DIR_N; i++) begin
      row = dir_rows[i];
      if (row.min_len != cur_min || row.sel != cur_sel) begin
        drain_out();
        cfg_apply(row.min_len, row.sel);
      end
      send_byte(row.data, row.fend);
      predict_beats(row.data, row.fend);
      if (row.lit) begin
        // expectation typed in, the shadow state still advances above
        beats_due.push_back('{row.data, KIND_DATA, 1'b0});
        if (row.fend) begin
          for (int p = 0; p < row.npad; p++) beats_due.push_back('{8'h00, KIND_PAD, 1'b0});
          for (int b = 0; b < FCS_LEN; b++) begin
            beats_due.push_back('{row.fcs[8*b +: 8], KIND_FCS, (b == FCS_LEN - 1)});
          end
        end
      end else begin
        foreach (pred_q[k]) beats_due.push_back(pred_q[k]);
      end
    end
    drain_out();

    // random part: phases of whole frames, each phase under one setting;
    // the first five phases always run so the long stall is always reached
    n_rand = 0;
    phase  = 0;
    while (n_rand < RAND_ITEMS || phase <= 4) begin
      case (phase)
        0: begin rmin = 7'd0;   rsel = FCS_CRC;  end
        1: begin rmin = 7'd127; rsel = FCS_GOOD; end
        2: begin rmin = 7'd64;  rsel = FCS_BAD;  end
        3: begin rmin = 7'd65;  rsel = 2'd3;     end
        default: begin
          case ($urandom_range(0, 4))
            0: rmin = 7'd0;
            1: rmin = 7'd64;
            2: rmin = 7'd127;
            3: rmin = 7'($urandom_range(65, 126));
            default: rmin = 7'($urandom_range(1, 63));
          endcase
          rsel = 2'($urandom_range(0, 3));
        end
      endcase
      cfg_apply(rmin, rsel);

      // some phases run back to back on both sides
      tx_no_gap = (phase % 5 == 2) || (phase == 4);
      rx_no_gap = (phase % 5 == 2);
      nfr = $urandom_range(1, 4);
      if (phase == 4) begin
        // receiver holds off while the sender keeps offering a long frame
        rx_hold_len = HOLD_LEN;
        nfr = 1;
      end

      for (int f = 0; f < nfr; f++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: flen = $urandom_range(1, 12);
          6, 7, 8:          flen = $urandom_range(13, 50);
          default:          flen = $urandom_range(55, 80);
        endcase
        if (phase == 4) flen = 40;
        for (int j = 0; j < flen; j++) begin
          logic [7:0] d;
          d = 8'($urandom_range(0, 255));
          send_byte(d, j == flen - 1);
          predict_beats(d, j == flen - 1);
          foreach (pred_q[k]) beats_due.push_back(pred_q[k]);
          n_rand++;
        end
      end
      // sender waits for every owed byte before the next setting
      drain_out();
      phase++;
    end

    tx_no_gap = 0;
    rx_no_gap = 0;
    drain_out();
    repeat (6) @(posedge clk);

    $display("covered %0d frames, %0d input bytes, %0d output bytes, %0d register settings",
             n_frames, n_in, n_beats, n_setting);
    $display("pad extremes, capped minimum, all fcs modes, mid-frame write, long stall");
    if (errors == 0 && beats_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/etxpad_pkg.sv
hw/rtl/etxpad_in_if.sv
hw/rtl/etxpad_out_if.sv
hw/rtl/etxpad_crc8.sv
hw/rtl/ethernet_tx_pad_and_fcs_insert_top.sv
tb/tb.sv
